/* hdl/vmtd_pkg.sv */
// ----------------------------------------------------------------------------
// vmtd_pkg
// Shared types and constants for the model-view-projection vertex transform:
// request and response payloads, fixed-point defaults and pipeline latency.
// ----------------------------------------------------------------------------
package vmtd_pkg;

   // Default number of fraction bits in the fixed-point format
   localparam int FRAC_BITS_DEFAULT = 16;

   // Quotient bits resolved by the divider, one per pipeline step
   localparam int QUO_BITS = 33;

   // Cycles from an accepted transform to its response strobe
   localparam int LATENCY = 9 + QUO_BITS;

   // Command codes
   localparam logic CMD_LOAD      = 1'b0;
   localparam logic CMD_TRANSFORM = 1'b1;

   // Request payload
   typedef struct packed {
      logic               command;
      logic [1:0]         matrix_select;
      logic [3:0]         entry_index;
      logic signed [31:0] entry_value;
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] vertex_z;
   } req_type;

   // Response payload
   typedef struct packed {
      logic signed [31:0] ndc_x;
      logic signed [31:0] ndc_y;
      logic signed [31:0] ndc_z;
      logic               w_zero;
      logic               saturated;
   } rsp_type;

endpackage

/* hdl/vertex_mvp_transform_divide_top.sv */
// ----------------------------------------------------------------------------
// vertex_mvp_transform_divide_top
// Path: capture, product and row-sum stages per matrix, divider, response.
// Throughput: one command per cycle; busy stays low, every command flows on.
// Loads travel the pipeline and write their matrix at the stage that reads it.
// The rate is set by the fully pipelined multiply stages and the divider,
// which resolves one quotient bit per stage over 33 stages.
// Reset: synchronous, active high; clears valid bits, matrices to identity.
// ----------------------------------------------------------------------------
module vertex_mvp_transform_divide_top #(
   parameter int FRAC_BITS = vmtd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  vmtd_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output vmtd_pkg::rsp_type rsp_data
);

   localparam int QB    = vmtd_pkg::QUO_BITS;
   localparam int NUM_W = 32 + FRAC_BITS;
   localparam int CW    = QB + 32;
   localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);
   localparam logic signed [65:0] S32_MAX = 66'sh7fffffff;
   localparam logic signed [65:0] S32_MIN = -66'sh80000000;

   typedef struct packed {
      logic               valid;
      logic               load;
      logic [1:0]         sel;
      logic [3:0]         idx;
      logic signed [31:0] val;
      logic               sat;
   } tag_type;

   typedef struct packed {
      logic        valid;
      logic        load;
      logic        sat;
      logic        wz;
      logic [31:0] wabs;
   } div_tag_type;

   // Matrix stores and transform pipeline
   logic signed [31:0] mat_in [3][16];
   logic signed [31:0] mat_ff [3][16];
   tag_type            stg_tag_in [4];
   tag_type            stg_tag_ff [4];
   logic signed [31:0] stg_vec_in [4][4];
   logic signed [31:0] stg_vec_ff [4][4];
   tag_type            mul_tag_in [3];
   tag_type            mul_tag_ff [3];
   logic signed [63:0] prod_in [3][16];
   logic signed [63:0] prod_ff [3][16];

   // Divider pipeline
   div_tag_type        div_tag_in [QB+1];
   div_tag_type        div_tag_ff [QB+1];
   logic [NUM_W-1:0]   rem_in [QB+1][3];
   logic [NUM_W-1:0]   rem_ff [QB+1][3];
   logic [QB-1:0]      quo_in [QB+1][3];
   logic [QB-1:0]      quo_ff [QB+1][3];
   logic               neg_in [QB+1][3];
   logic               neg_ff [QB+1][3];
   logic               ovf_in [QB+1][3];
   logic               ovf_ff [QB+1][3];

   vmtd_pkg::rsp_type  rsp_in, rsp_ff;
   logic               rsp_valid_in, rsp_valid_ff;

   // No back-pressure anywhere in the pipeline
   assign busy = 1'b0;

   always_comb begin
      logic signed [65:0] acc;
      logic signed [31:0] w;
      logic signed [31:0] n;
      logic [31:0]        nabs;
      logic [CW-1:0]      trial;
      logic [QB-1:0]      mag;
      logic [QB-1:0]      sgn;
      logic               clip;
      logic signed [31:0] res [3];
      logic               dsat;

      // Capture the command
      stg_tag_in[0].valid = start && !busy;
      stg_tag_in[0].load  = (req_data.command == vmtd_pkg::CMD_LOAD);
      stg_tag_in[0].sel   = req_data.matrix_select;
      stg_tag_in[0].idx   = req_data.entry_index;
      stg_tag_in[0].val   = req_data.entry_value;
      stg_tag_in[0].sat   = 1'b0;
      stg_vec_in[0][0]    = req_data.vertex_x;
      stg_vec_in[0][1]    = req_data.vertex_y;
      stg_vec_in[0][2]    = req_data.vertex_z;
      stg_vec_in[0][3]    = ONE;

      for (int m = 0; m < 3; m++) begin
         // Write a load into its matrix as it passes that matrix's stage
         mat_in[m] = mat_ff[m];
         if (stg_tag_ff[m].valid && stg_tag_ff[m].load && stg_tag_ff[m].sel == 2'(m)) begin
            mat_in[m][stg_tag_ff[m].idx] = stg_tag_ff[m].val;
         end
         // Form all sixteen products
         mul_tag_in[m] = stg_tag_ff[m];
         for (int e = 0; e < 16; e++) begin
            prod_in[m][e] = 64'(mat_ff[m][e]) * 64'(stg_vec_ff[m][e % 4]);
         end
         // Sum each row of floored products and clamp
         stg_tag_in[m+1] = mul_tag_ff[m];
         for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int c = 0; c < 4; c++) begin
               acc = acc + 66'(prod_ff[m][r*4+c] >>> FRAC_BITS);
            end
            if (acc > S32_MAX) begin
               stg_vec_in[m+1][r]  = 32'h7fffffff;
               stg_tag_in[m+1].sat = 1'b1;
            end else if (acc < S32_MIN) begin
               stg_vec_in[m+1][r]  = 32'h80000000;
               stg_tag_in[m+1].sat = 1'b1;
            end else begin
               stg_vec_in[m+1][r] = acc[31:0];
            end
         end
      end

      // Set up the divide: magnitudes, signs and early overflow
      w = stg_vec_ff[3][3];
      div_tag_in[0].valid = stg_tag_ff[3].valid;
      div_tag_in[0].load  = stg_tag_ff[3].load;
      div_tag_in[0].sat   = stg_tag_ff[3].sat;
      div_tag_in[0].wz    = (w == 32'sd0);
      div_tag_in[0].wabs  = w[31] ? 32'(-w) : 32'(w);
      for (int i = 0; i < 3; i++) begin
         n    = stg_vec_ff[3][i];
         nabs = n[31] ? 32'(-n) : 32'(n);
         rem_in[0][i] = {nabs, FRAC_BITS'(0)};
         quo_in[0][i] = '0;
         neg_in[0][i] = n[31] ^ w[31];
         ovf_in[0][i] = (CW'({nabs, FRAC_BITS'(0)}) >> QB) >= CW'(div_tag_in[0].wabs);
      end

      // Resolve one quotient bit per stage, most significant first
      for (int j = 0; j < QB; j++) begin
         div_tag_in[j+1] = div_tag_ff[j];
         for (int i = 0; i < 3; i++) begin
            trial            = CW'(div_tag_ff[j].wabs) << (QB - 1 - j);
            rem_in[j+1][i]   = rem_ff[j][i];
            quo_in[j+1][i]   = quo_ff[j][i];
            neg_in[j+1][i]   = neg_ff[j][i];
            ovf_in[j+1][i]   = ovf_ff[j][i];
            if (CW'(rem_ff[j][i]) >= trial) begin
               rem_in[j+1][i]             = NUM_W'(CW'(rem_ff[j][i]) - trial);
               quo_in[j+1][i][QB - 1 - j] = 1'b1;
            end
         end
      end

      // Apply signs, clamp and handle a zero w
      dsat = div_tag_ff[QB].sat;
      for (int i = 0; i < 3; i++) begin
         mag  = quo_ff[QB][i];
         clip = ovf_ff[QB][i] ||
                (neg_ff[QB][i] ? (mag > 33'h080000000) : (mag > 33'h07fffffff));
         sgn  = neg_ff[QB][i] ? QB'(-mag) : mag;
         if (clip) begin
            res[i] = neg_ff[QB][i] ? 32'h80000000 : 32'h7fffffff;
            dsat   = 1'b1;
         end else begin
            res[i] = sgn[31:0];
         end
      end
      if (div_tag_ff[QB].wz) begin
         rsp_in.ndc_x     = '0;
         rsp_in.ndc_y     = '0;
         rsp_in.ndc_z     = '0;
         rsp_in.w_zero    = 1'b1;
         rsp_in.saturated = div_tag_ff[QB].sat;
      end else begin
         rsp_in.ndc_x     = res[0];
         rsp_in.ndc_y     = res[1];
         rsp_in.ndc_z     = res[2];
         rsp_in.w_zero    = 1'b0;
         rsp_in.saturated = dsat;
      end
      rsp_valid_in = div_tag_ff[QB].valid && !div_tag_ff[QB].load;
   end

   // Advance every stage each cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < 3; m++) begin
            for (int e = 0; e < 16; e++) begin
               mat_ff[m][e] <= (e % 5 == 0) ? ONE : 32'sd0;
            end
            mul_tag_ff[m].valid <= 1'b0;
         end
         for (int k = 0; k < 4; k++) begin
            stg_tag_ff[k].valid <= 1'b0;
         end
         for (int j = 0; j <= QB; j++) begin
            div_tag_ff[j].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         mat_ff       <= mat_in;
         stg_tag_ff   <= stg_tag_in;
         mul_tag_ff   <= mul_tag_in;
         div_tag_ff   <= div_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stg_vec_ff <= stg_vec_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      neg_ff     <= neg_in;
      ovf_ff     <= ovf_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/vmtd_checker.sv */
// ----------------------------------------------------------------------------
// vmtd_assert
// Port-level checks of the vertex transform: reset flush, zero-w results
// and the fixed latency between a transform transfer and its response.
// ----------------------------------------------------------------------------
module vmtd_assert (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input vmtd_pkg::req_type req_data,
   input logic              rsp_valid,
   input vmtd_pkg::rsp_type rsp_data
);

   // Reset empties the pipeline
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response strobe right after reset");

   // A zero w forces the coordinates to zero
   a_w_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.w_zero |->
         rsp_data.ndc_x == 32'sd0 && rsp_data.ndc_y == 32'sd0 && rsp_data.ndc_z == 32'sd0)
      else $error("nonzero coordinates with w_zero");

   // Every response comes from a transform transfer a fixed time back
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy &&
                          req_data.command == vmtd_pkg::CMD_TRANSFORM, vmtd_pkg::LATENCY))
      else $error("response without matching transform transfer");

endmodule

bind vertex_mvp_transform_divide_top vmtd_assert u_vmtd_assert (.*);
